// ===== rtl/core/cpio_pkg.sv =====
// Package for the newc archive stream parser: phase, result kind, status and
// name class codes. No dependencies.
`timescale 1ns / 1ps

package cpio_pkg;

   typedef enum logic [2:0] {
      PH_HEADER       = 3'd0,
      PH_NAME         = 3'd1,
      PH_NPAD_NORMAL  = 3'd2,
      PH_NPAD_DOT     = 3'd3,
      PH_NPAD_TRAILER = 3'd4,
      PH_DATA         = 3'd5,
      PH_DPAD         = 3'd6,
      PH_SEARCH       = 3'd7
   } phase_type;

   localparam logic [2:0] KIND_HEADER   = 3'd0;
   localparam logic [2:0] KIND_NAME     = 3'd1;
   localparam logic [2:0] KIND_NAME_END = 3'd2;
   localparam logic [2:0] KIND_DATA     = 3'd3;
   localparam logic [2:0] KIND_STATUS   = 3'd4;

   localparam logic [2:0] ST_OK         = 3'd0;
   localparam logic [2:0] ST_TOO_SHORT  = 3'd1;
   localparam logic [2:0] ST_BAD_MAGIC  = 3'd2;
   localparam logic [2:0] ST_BAD_FIELD  = 3'd3;
   localparam logic [2:0] ST_NAME_OVER  = 3'd4;
   localparam logic [2:0] ST_DATA_OVER  = 3'd5;

   localparam logic [1:0] CLS_NORMAL  = 2'd0;
   localparam logic [1:0] CLS_DOT     = 2'd1;
   localparam logic [1:0] CLS_DOTDOT  = 2'd2;
   localparam logic [1:0] CLS_TRAILER = 2'd3;

   localparam logic [6:0] HDR_LEN   = 7'd110;
   localparam logic [6:0] OFF_MODE  = 7'd14;
   localparam logic [6:0] OFF_FSIZE = 7'd54;
   localparam logic [6:0] OFF_NSIZE = 7'd94;
   localparam logic [47:0] MAGIC_070701 = 48'h303730373031;

   function automatic logic [7:0] trailer_char(input logic [3:0] i);
      logic [7:0] c;
      unique case (i)
         4'd0: c = 8'h54;
         4'd1: c = 8'h52;
         4'd2: c = 8'h41;
         4'd3: c = 8'h49;
         4'd4: c = 8'h4C;
         4'd5: c = 8'h45;
         4'd6: c = 8'h52;
         default: c = 8'h21;
      endcase
      return c;
   endfunction

   typedef struct packed {
      logic       ok;
      logic [3:0] value;
   } hex_type;

endpackage

// ===== rtl/core/cpio_newc_stream_parser.sv =====
// newc archive stream parser: one request per cycle; where a request yields a
// result, it is in the output register in the next cycle. A request is taken
// as long as that register is free or being drained in the same cycle, so
// throughput is one byte per cycle then; all state is running registers.
// Synchronous reset returns to header phase; the end request also resets.
`timescale 1ns / 1ps

module cpio_newc_stream_parser import cpio_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_op,
   input  logic [7:0]  req_byte_in,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_kind,
   output logic [31:0] rsp_file_mode,
   output logic [31:0] rsp_file_size,
   output logic [31:0] rsp_name_size,
   output logic [7:0]  rsp_value,
   output logic [1:0]  rsp_name_class,
   output logic        rsp_last_data,
   output logic [2:0]  rsp_status
);

   phase_type   phase_ff, phase_in;
   logic [6:0]  hoff_ff, hoff_in;
   logic [31:0] total_ff, total_in;
   logic [31:0] mode_ff, mode_in, size_ff, size_in, nlen_ff, nlen_in;
   logic [31:0] rem_ff, rem_in;
   logic [2:0]  match_ff, match_in;
   logic [47:0] win_ff, win_in;
   logic [2:0]  perr_ff, perr_in;
   logic        halt_ff, halt_in;

   logic        ov_ff, ov_in;
   logic [2:0]  kind_ff, kind_in;
   logic [7:0]  val_ff, val_in;
   logic [1:0]  cls_ff, cls_in;
   logic        last_ff, last_in;
   logic [2:0]  st_ff, st_in;

   hex_type     digit;
   logic        take, emit, aligned;
   logic [31:0] idx, len, rem_dec;
   logic [1:0]  cls;
   logic [2:0]  fin;

   cpio_hex u_hex (.char_in(req_byte_in), .digit(digit));

   assign req_ready = !ov_ff || rsp_ready;
   assign take      = req_valid && req_ready;

   always_comb begin
      if (total_ff < 32'(HDR_LEN))                       fin = ST_TOO_SHORT;
      else if (halt_ff)                                  fin = perr_ff;
      else if (phase_ff == PH_NAME)                      fin = ST_NAME_OVER;
      else if (phase_ff == PH_NPAD_NORMAL || phase_ff == PH_DATA) fin = ST_DATA_OVER;
      else                                               fin = ST_OK;
   end

   always_comb begin
      phase_in = phase_ff; hoff_in = hoff_ff; total_in = total_ff;
      mode_in = mode_ff; size_in = size_ff; nlen_in = nlen_ff; rem_in = rem_ff;
      match_in = match_ff; win_in = win_ff; perr_in = perr_ff; halt_in = halt_ff;
      emit = 1'b0; kind_in = kind_ff; val_in = 8'd0; cls_in = CLS_NORMAL;
      last_in = 1'b0; st_in = ST_OK;
      idx = nlen_ff - rem_ff;
      len = nlen_ff - 32'd1;
      rem_dec = rem_ff - 32'd1;
      cls = CLS_NORMAL;
      aligned = 1'b0;
      if (take && req_op) begin
         emit = 1'b1; kind_in = KIND_STATUS; st_in = fin;
         phase_in = PH_HEADER; hoff_in = 7'd0; total_in = 32'd0;
         mode_in = 32'd0; size_in = 32'd0; nlen_in = 32'd0; rem_in = 32'd0;
         match_in = 3'b111; win_in = 48'd0; perr_in = ST_OK; halt_in = 1'b0;
      end else if (take) begin
         total_in = (total_ff == 32'hFFFF_FFFF) ? 32'd128 : total_ff + 32'd1;
         aligned  = (total_in[1:0] == 2'd0);
         if (!halt_ff) begin
            unique case (phase_ff)
               PH_HEADER: begin
                  if (hoff_ff < 7'd5) begin
                     if (req_byte_in != ((hoff_ff[0]) ? 8'h37 : 8'h30) && perr_ff == ST_OK)
                        perr_in = ST_BAD_MAGIC;
                  end else if (hoff_ff == 7'd5) begin
                     if (req_byte_in != 8'h31 && req_byte_in != 8'h32 && perr_ff == ST_OK)
                        perr_in = ST_BAD_MAGIC;
                  end else if ((hoff_ff >= OFF_MODE && hoff_ff < OFF_MODE + 7'd8) ||
                               (hoff_ff >= OFF_FSIZE && hoff_ff < OFF_FSIZE + 7'd8) ||
                               (hoff_ff >= OFF_NSIZE && hoff_ff < OFF_NSIZE + 7'd8)) begin
                     if (!digit.ok) begin
                        if (perr_ff == ST_OK) perr_in = ST_BAD_FIELD;
                     end else if (hoff_ff < OFF_MODE + 7'd8) begin
                        mode_in = {mode_ff[27:0], digit.value};
                     end else if (hoff_ff < OFF_FSIZE + 7'd8) begin
                        size_in = {size_ff[27:0], digit.value};
                     end else begin
                        nlen_in = {nlen_ff[27:0], digit.value};
                     end
                  end
                  hoff_in = hoff_ff + 7'd1;
                  if (hoff_ff + 7'd1 >= HDR_LEN) begin
                     hoff_in = 7'd0;
                     if (perr_in != ST_OK) begin
                        halt_in = 1'b1;
                     end else if (nlen_in == 32'd0) begin
                        perr_in = ST_NAME_OVER; halt_in = 1'b1;
                     end else begin
                        phase_in = PH_NAME; rem_in = nlen_in; match_in = 3'b111;
                        emit = 1'b1; kind_in = KIND_HEADER;
                     end
                  end
               end
               PH_NAME: begin
                  if (rem_ff > 32'd1) begin
                     if (!(idx == 32'd0 && req_byte_in == 8'h2E)) match_in[0] = 1'b0;
                     if (!(idx < 32'd2 && req_byte_in == 8'h2E)) match_in[1] = 1'b0;
                     if (!(idx < 32'd10 && req_byte_in == trailer_char(idx[3:0])))
                        match_in[2] = 1'b0;
                     rem_in = rem_dec;
                     emit = 1'b1; kind_in = KIND_NAME; val_in = req_byte_in;
                  end else begin
                     if (match_ff[2] && len == 32'd10)     cls = CLS_TRAILER;
                     else if (match_ff[1] && len == 32'd2) cls = CLS_DOTDOT;
                     else if (match_ff[0] && len == 32'd1) cls = CLS_DOT;
                     rem_in = 32'd0;
                     emit = 1'b1; kind_in = KIND_NAME_END; cls_in = cls;
                     if (!aligned) begin
                        phase_in = (cls == CLS_NORMAL) ? PH_NPAD_NORMAL :
                                   (cls == CLS_TRAILER) ? PH_NPAD_TRAILER : PH_NPAD_DOT;
                     end else if (cls == CLS_NORMAL) begin
                        if (size_ff == 32'd0) begin
                           phase_in = PH_HEADER; hoff_in = 7'd0; perr_in = ST_OK;
                        end else begin
                           phase_in = PH_DATA; rem_in = size_ff;
                        end
                     end else if (cls == CLS_TRAILER) begin
                        phase_in = PH_SEARCH; hoff_in = 7'd0; win_in = 48'd0;
                     end else begin
                        phase_in = PH_HEADER; hoff_in = 7'd0; perr_in = ST_OK;
                     end
                  end
               end
               PH_NPAD_NORMAL: begin
                  if (aligned) begin
                     if (size_ff == 32'd0) begin
                        phase_in = PH_HEADER; hoff_in = 7'd0; perr_in = ST_OK;
                     end else begin
                        phase_in = PH_DATA; rem_in = size_ff;
                     end
                  end
               end
               PH_NPAD_DOT, PH_DPAD: begin
                  if (aligned) begin
                     phase_in = PH_HEADER; hoff_in = 7'd0; perr_in = ST_OK;
                  end
               end
               PH_NPAD_TRAILER: begin
                  if (aligned) begin
                     phase_in = PH_SEARCH; hoff_in = 7'd0; win_in = 48'd0;
                  end
               end
               PH_DATA: begin
                  rem_in = rem_dec;
                  emit = 1'b1; kind_in = KIND_DATA; val_in = req_byte_in;
                  if (rem_dec == 32'd0) begin
                     last_in = 1'b1;
                     if (aligned) begin
                        phase_in = PH_HEADER; hoff_in = 7'd0; perr_in = ST_OK;
                     end else begin
                        phase_in = PH_DPAD;
                     end
                  end
               end
               PH_SEARCH: begin
                  win_in = {win_ff[39:0], req_byte_in};
                  if (hoff_ff < 7'd6) hoff_in = hoff_ff + 7'd1;
                  if (hoff_in >= 7'd6 && win_in == MAGIC_070701) begin
                     phase_in = PH_HEADER; hoff_in = 7'd6; perr_in = ST_OK;
                  end
               end
               default: ;
            endcase
         end
      end
      ov_in = emit ? 1'b1 : (rsp_ready ? 1'b0 : ov_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HEADER; hoff_ff <= 7'd0; total_ff <= 32'd0;
         mode_ff <= 32'd0; size_ff <= 32'd0; nlen_ff <= 32'd0; rem_ff <= 32'd0;
         match_ff <= 3'b111; win_ff <= 48'd0; perr_ff <= ST_OK; halt_ff <= 1'b0;
         ov_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in; hoff_ff <= hoff_in; total_ff <= total_in;
         mode_ff <= mode_in; size_ff <= size_in; nlen_ff <= nlen_in; rem_ff <= rem_in;
         match_ff <= match_in; win_ff <= win_in; perr_ff <= perr_in; halt_ff <= halt_in;
         ov_ff <= ov_in;
      end
   end

   logic [31:0] omode_ff, osize_ff, onlen_ff;

   always_ff @(posedge clock) begin
      if (emit) begin
         kind_ff <= kind_in; val_ff <= val_in; cls_ff <= cls_in;
         last_ff <= last_in; st_ff <= st_in;
         omode_ff <= (kind_in == KIND_HEADER) ? mode_in : 32'd0;
         osize_ff <= (kind_in == KIND_HEADER) ? size_in : 32'd0;
         onlen_ff <= (kind_in == KIND_HEADER) ? nlen_in : 32'd0;
      end
   end

   assign rsp_valid      = ov_ff;
   assign rsp_kind       = kind_ff;
   assign rsp_file_mode  = omode_ff;
   assign rsp_file_size  = osize_ff;
   assign rsp_name_size  = onlen_ff;
   assign rsp_value      = val_ff;
   assign rsp_name_class = cls_ff;
   assign rsp_last_data  = last_ff;
   assign rsp_status     = st_ff;

endmodule

// ===== rtl/core/cpio_hex.sv =====
// Hex digit decoder for header fields.
// Depends on cpio_pkg.
`timescale 1ns / 1ps

module cpio_hex import cpio_pkg::*; (
   input  logic [7:0] char_in,
   output hex_type    digit
);

   always_comb begin
      digit = '{ok: 1'b0, value: 4'd0};
      if (char_in >= 8'h30 && char_in <= 8'h39) begin
         digit = '{ok: 1'b1, value: 4'(char_in - 8'h30)};
      end else if (char_in >= 8'h61 && char_in <= 8'h66) begin
         digit = '{ok: 1'b1, value: 4'(char_in - 8'h57)};
      end else if (char_in >= 8'h41 && char_in <= 8'h46) begin
         digit = '{ok: 1'b1, value: 4'(char_in - 8'h37)};
      end
   end

endmodule
